// ----- design/lsi_pkg.sv -----
// ----------------------------------------------------------------------------
// lsi_pkg
// shared types, constants and arithmetic helpers of the lms system
// identification block
// ----------------------------------------------------------------------------
`default_nettype none

package lsi_pkg;

	localparam int SMP_W   = 16;         // sample and output width
	localparam int W_W     = 48;         // adaptive weight width
	localparam int ACC_W   = 64;         // y and e accumulator width
	localparam int D_W     = 35;         // reference sum width, exact for eight taps
	localparam int NREG    = 8;          // number of reference coefficient registers
	localparam int CI_W    = 3;          // coefficient index width
	localparam int CFG_IDX_W = 4;        // configuration index width
	localparam int Y_FRAC  = 40;
	localparam int D_FRAC  = 15;
	localparam int D_ALIGN = 25;         // d to 40 fraction bits
	localparam logic signed [SMP_W-1:0] COEF_RST = 16'sd4096;

	typedef logic signed [SMP_W-1:0] smp_t;
	typedef logic signed [W_W-1:0]   weight_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		smp_t sample_in;
	} in_word_t;

	typedef struct packed {
		smp_t adaptive_out;
		smp_t reference_out;
		smp_t error_out;
	} out_word_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [SMP_W-1:0]     value;
	} cfg_word_t;

	// controller to datapath commands
	typedef struct packed {
		logic clr;       // clearing pass write at tap index
		logic load;      // take new sample, clear accumulators
		logic tap_vld;   // issue one tap of a pass
		logic pass2;     // tap belongs to the weight update pass
		logic err;       // form the error
		logic out_load;  // load the result register
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} status_t;

	function automatic acc_t sat_add64(acc_t a, acc_t b);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1])
			return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		return s[ACC_W-1:0];
	endfunction

	// integer part of a magnitude already shifted down, saturated to 16 bits
	function automatic smp_t int16_sat(logic neg, logic [ACC_W-1:0] m);
		if (!neg)
			return (m > 64'd32767) ? 16'sd32767 : smp_t'(m[SMP_W-1:0]);
		if (m > 64'd32768)
			return -16'sd32768;
		return smp_t'(-m[SMP_W-1:0]);
	endfunction

	function automatic logic [ACC_W-1:0] mag64(acc_t v);
		return v[ACC_W-1] ? (~v + 64'd1) : v;
	endfunction

endpackage

`default_nettype wire

// ----- design/lsi_stream_if.sv -----
// ----------------------------------------------------------------------------
// lsi_stream_if
// valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
`default_nettype none

interface lsi_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/lsi_ram.sv -----
// ----------------------------------------------------------------------------
// lsi_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lsi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 120
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

`default_nettype wire

// ----- design/lsi_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsi_ctrl
// sequencer: clearing pass, filter pass, error, update pass, result load
// ----------------------------------------------------------------------------
`default_nettype none

module lsi_ctrl
	import lsi_pkg::*;
#(
	parameter int TAPS = 120
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire status_t                 status,
	output cmd_t                         cmd,
	output logic [$clog2(TAPS)-1:0]      tap_idx
);
	localparam int AW = $clog2(TAPS);
	localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_P1   = 3'd2;
	localparam logic [2:0] S_D1   = 3'd3;
	localparam logic [2:0] S_ERR  = 3'd4;
	localparam logic [2:0] S_P2   = 3'd5;
	localparam logic [2:0] S_D2   = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0]    state_q;
	logic [AW-1:0] cnt_q;

	assign tap_idx  = cnt_q;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.clr      = (state_q == S_CLR);
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.tap_vld  = (state_q == S_P1) || (state_q == S_P2);
		cmd.pass2    = (state_q == S_P2);
		cmd.err      = (state_q == S_ERR);
		cmd.out_load = (state_q == S_OUT) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLR, S_P1, S_P2: begin
					cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + 1'b1;
					if (cnt_q == LAST)
						state_q <= (state_q == S_CLR) ? S_IDLE :
							(state_q == S_P1) ? S_D1 : S_D2;
				end
				S_IDLE: if (in_valid) state_q <= S_P1;
				S_D1:   if (!status.pipe_busy) state_q <= S_ERR;
				S_ERR:  state_q <= S_P2;
				S_D2:   if (!status.pipe_busy) state_q <= S_OUT;
				S_OUT:  if (status.out_free) state_q <= S_IDLE;
				default: state_q <= S_CLR;
			endcase
		end
	end
endmodule

`default_nettype wire

// ----- design/lsi_datapath.sv -----
// ----------------------------------------------------------------------------
// lsi_datapath
// delay line and weight rams, multiply pipeline, accumulators, result register
// ----------------------------------------------------------------------------
`default_nettype none

module lsi_datapath
	import lsi_pkg::*;
#(
	parameter int TAPS       = 120,
	parameter int REF_TAPS   = 8,
	parameter int STEP_SHIFT = 36
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cmd_t                    cmd,
	input  wire logic [$clog2(TAPS)-1:0] tap_idx,
	output status_t                      status,
	input  wire smp_t                    sample_in,
	input  wire logic                    cfg_we,
	input  wire cfg_word_t               cfg_word,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output out_word_t                    out_word
);
	localparam int AW = $clog2(TAPS);
	localparam int PW = ACC_W + SMP_W;
	localparam logic [AW-1:0] LAST = AW'(TAPS - 1);
	localparam logic [PW-1:0] CAP = PW'(1) << W_W;

	smp_t          coef_q [NREG];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] wp_nxt, x_raddr;
	acc_t          y_q, e_q;
	logic signed [D_W-1:0] d_q;

	logic [SMP_W-1:0] x_rd;
	logic [W_W-1:0]   w_rd;
	logic             x_we, w_we;
	logic [AW-1:0]    x_waddr, w_waddr;
	logic [SMP_W-1:0] x_wdata;
	logic [W_W-1:0]   w_wdata;

	logic             vld_s1, p2_s1, vld_s2, p2_s2, neg_s2;
	logic [AW-1:0]    n_s1, n_s2;
	weight_t          w_s2;
	logic [PW-1:0]    prod_s2;
	logic signed [2*SMP_W-1:0] dprod_s2;

	smp_t             x_s;
	logic [SMP_W-1:0] ax;
	logic             ref_hit;
	logic [PW-1:0]    sh;
	logic [W_W:0]     tmag;
	logic signed [W_W+1:0] wsum;
	weight_t          wnew;
	acc_t             d_al;
	logic signed [ACC_W:0] ediff;
	logic             out_valid_q;
	out_word_t        out_q;

	assign wp_nxt  = (wp_q == LAST) ? '0 : wp_q + 1'b1;
	assign x_raddr = (wp_q >= tap_idx) ? wp_q - tap_idx : AW'(wp_q + TAPS - tap_idx);

	assign x_we    = cmd.clr || cmd.load;
	assign x_waddr = cmd.clr ? tap_idx : wp_nxt;
	assign x_wdata = cmd.clr ? '0 : sample_in;

	lsi_ram #(.WIDTH(SMP_W), .DEPTH(TAPS)) u_xram (
		.clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
		.raddr(x_raddr), .rdata(x_rd)
	);

	lsi_ram #(.WIDTH(W_W), .DEPTH(TAPS)) u_wram (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(tap_idx), .rdata(w_rd)
	);

	// stage 1 multiply
	assign x_s     = smp_t'(x_rd);
	assign ax      = x_s[SMP_W-1] ? -x_rd : x_rd;
	assign ref_hit = ({1'b0, n_s1} < (AW+1)'(REF_TAPS));

	always_ff @(posedge clk) begin
		n_s1 <= tap_idx;
		p2_s1 <= cmd.pass2;
		n_s2 <= n_s1;
		p2_s2 <= p2_s1;
		w_s2 <= weight_t'(w_rd);
		neg_s2 <= e_q[ACC_W-1] ^ x_s[SMP_W-1];
		if (p2_s1)
			prod_s2 <= mag64(e_q) * ax;
		else
			prod_s2 <= PW'(acc_t'(weight_t'(w_rd)) * acc_t'(x_s));
		if (ref_hit)
			dprod_s2 <= coef_q[n_s1[CI_W-1:0]] * x_s;
		else
			dprod_s2 <= '0;
	end

	// stage 2 update term and saturated weight
	assign sh   = prod_s2 >> STEP_SHIFT;
	assign tmag = (sh > CAP) ? CAP[W_W:0] : sh[W_W:0];
	assign wsum = {{2{w_s2[W_W-1]}}, w_s2} +
		(neg_s2 ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag}));
	always_comb begin
		if (wsum > $signed({{2{1'b0}}, {1'b0, {(W_W-1){1'b1}}}}))
			wnew = {1'b0, {(W_W-1){1'b1}}};
		else if (wsum < $signed({{2{1'b1}}, {1'b1, {(W_W-1){1'b0}}}}))
			wnew = {1'b1, {(W_W-1){1'b0}}};
		else
			wnew = wsum[W_W-1:0];
	end

	assign w_we    = cmd.clr || (vld_s2 && p2_s2);
	assign w_waddr = cmd.clr ? tap_idx : n_s2;
	assign w_wdata = cmd.clr ? '0 : wnew;

	assign d_al  = acc_t'(d_q) <<< D_ALIGN;
	assign ediff = {d_al[ACC_W-1], d_al} - {y_q[ACC_W-1], y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			wp_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NREG; i++)
				coef_q[i] <= COEF_RST;
		end else begin
			vld_s1 <= cmd.tap_vld;
			vld_s2 <= vld_s1;
			if (cmd.load)
				wp_q <= wp_nxt;
			if (cfg_we && cfg_word.index < CFG_IDX_W'(NREG))
				coef_q[cfg_word.index[CI_W-1:0]] <= smp_t'(cfg_word.value);
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			y_q <= '0;
			d_q <= '0;
		end else if (vld_s2 && !p2_s2) begin
			y_q <= sat_add64(y_q, acc_t'(prod_s2[ACC_W-1:0]));
			d_q <= d_q + D_W'(dprod_s2);
		end
		if (cmd.err) begin
			if (ediff[ACC_W] != ediff[ACC_W-1])
				e_q <= ediff[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
			else
				e_q <= ediff[ACC_W-1:0];
		end
		if (cmd.out_load) begin
			out_q.adaptive_out  <= int16_sat(y_q[ACC_W-1], mag64(y_q) >> Y_FRAC);
			out_q.reference_out <= int16_sat(d_q[D_W-1], mag64(acc_t'(d_q)) >> D_FRAC);
			out_q.error_out     <= int16_sat(e_q[ACC_W-1], mag64(e_q) >> Y_FRAC);
		end
	end

	assign status.pipe_busy = vld_s1 || vld_s2;
	assign status.out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;
endmodule

`default_nettype wire

// ----- design/lms_system_identification_unit.sv -----
// ----------------------------------------------------------------------------
// lms_system_identification_unit
// lms adaptive fir system identification against a configurable reference fir
// ----------------------------------------------------------------------------
// Each sample word enters a TAPS-deep delay line; an 8-tap reference fir gives
// d, the adaptive fir gives y, and every weight moves by e*x >> STEP_SHIFT.
// Once a sample is accepted, the block runs the filter pass at one tap a cycle
// through the shared multiply pipeline, lets the pipeline drain, forms the
// error, runs the update pass the same way, drains again and loads the result
// word; the next sample is taken only after that result load, and a result
// word left waiting in the output register holds the following sample at its
// result load. After reset a clearing pass zeroes both rams before the first
// sample is taken; configuration writes are accepted at all times and should
// only be made while no sample is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module lms_system_identification_unit
	import lsi_pkg::*;
#(
	parameter int TAPS       = 120,
	parameter int REF_TAPS   = 8,
	parameter int STEP_SHIFT = 36
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	lsi_stream_if.sink   sample,
	lsi_stream_if.source result,
	lsi_stream_if.sink   cfg
);
	cmd_t                 cmd;
	status_t              status;
	logic [$clog2(TAPS)-1:0] tap_idx;
	logic                 in_ready;

	// coefficient register writes are always accepted; an index past the last register is ignored
	assign cfg.ready    = 1'b1;
	assign sample.ready = in_ready;

	lsi_ctrl #(.TAPS(TAPS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(sample.valid), .in_ready(in_ready),
		.status(status), .cmd(cmd), .tap_idx(tap_idx)
	);

	lsi_datapath #(
		.TAPS(TAPS), .REF_TAPS(REF_TAPS), .STEP_SHIFT(STEP_SHIFT)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .tap_idx(tap_idx), .status(status),
		.sample_in(sample.data.sample_in),
		.cfg_we(cfg.valid), .cfg_word(cfg.data),
		.out_valid(result.valid), .out_ready(result.ready),
		.out_word(result.data)
	);
endmodule

`default_nettype wire

// ----- tb/tb_lms_system_identification_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lms_system_identification_unit
// self-checking bench for the lms system identification block
// ----------------------------------------------------------------------------
// Drives sample words through a valid/ready channel with random gaps. The
// reference coefficients are rewritten between phases while the block is idle.
// Each result word is checked against a bit-true model of the delay line, the
// reference fir, the adaptive fir and the weight update held in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lms_system_identification_unit;
	import lsi_pkg::*;

	localparam int    TAPS       = 120;
	localparam int    REF_TAPS   = 8;
	localparam int    STEP_SHIFT = 36;
	localparam int    DRAIN      = 400;      // longer than one sample's processing time
	localparam int    LONG_HOLD  = 2000;     // receiver hold-off that fills the block
	localparam longint MAX_CYC   = 3000000;
	localparam longint W_HI      = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint W_LO      = -W_HI - 1;
	localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = CFG_IDX_W'(NREG);

	logic clk;
	logic arst_n;

	lsi_stream_if #(.payload_t(in_word_t))  smp_ch ();
	lsi_stream_if #(.payload_t(out_word_t)) res_ch ();
	lsi_stream_if #(.payload_t(cfg_word_t)) cfg_ch ();

	lms_system_identification_unit #(
		.TAPS(TAPS), .REF_TAPS(REF_TAPS), .STEP_SHIFT(STEP_SHIFT)
	) dut (
		.clk(clk), .arst_n(arst_n), .sample(smp_ch), .result(res_ch), .cfg(cfg_ch)
	);

	// bench copy of the block state
	smp_t   taps_hist [TAPS];
	longint weights   [TAPS];
	smp_t   ref_coef  [NREG];

	out_word_t pending_words [$];
	int        fail_count;
	int        sent_count;
	int        rcvd_count;
	longint    cycle_count;

	// directed stimulus; typed expectations only where obvious from reset
	typedef struct {
		smp_t      smp;
		bit        typed;
		out_word_t want;
	} dir_row_t;

	dir_row_t dir_rows [] = '{
		'{16'sh7FFF, 1'b1, '{16'sd0, 16'sd4095, 16'sd4095}},  // first word after reset
		'{-16'sd32768, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{16'sd0,      1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{16'sd1,      1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{-16'sd1,     1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{16'sh5555,   1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{16'shAAAA,   1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{16'sh7FFF,   1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{16'sh7FFF,   1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{16'sh7FFF,   1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{16'sh7FFF,   1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{-16'sd32768, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{-16'sd32768, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{-16'sd32768, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{-16'sd32768, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{16'sd256,    1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{-16'sd256,   1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{16'sh7FFF,   1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{-16'sd32768, 1'b0, '{16'sd0, 16'sd0, 16'sd0}},
		'{16'sd0,      1'b0, '{16'sd0, 16'sd0, 16'sd0}}
	};

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run watchdog
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > MAX_CYC) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic longint sat_sum(longint a, longint b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic logic [63:0] abs64(longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	// integer part toward zero, saturated to 16 bits
	function automatic smp_t whole16(longint v, int frac);
		logic [63:0] m;
		m = abs64(v) >> frac;
		if (v >= 0)
			return (m > 64'd32767) ? 16'sh7FFF : smp_t'(m[15:0]);
		return (m > 64'd32768) ? -16'sd32768 : smp_t'(-m[15:0]);
	endfunction

	// shift in one sample, filter both ways, adapt weights
	function automatic out_word_t lms_advance(smp_t x);
		longint      d_sum;
		longint      y_sum;
		longint      err;
		longint      step;
		longint      w_new;
		logic [127:0] prod;
		logic [127:0] shifted;
		out_word_t   r;
		for (int n = TAPS - 1; n > 0; n--) taps_hist[n] = taps_hist[n-1];
		taps_hist[0] = x;
		d_sum = 0;
		for (int n = 0; n < REF_TAPS; n++)
			d_sum += longint'(ref_coef[n]) * longint'(taps_hist[n]);
		y_sum = 0;
		for (int n = 0; n < TAPS; n++)
			y_sum = sat_sum(y_sum, weights[n] * longint'(taps_hist[n]));
		// d aligned to 40 fraction bits, then saturating subtract
		if (y_sum == {1'b1, 63'd0})
			err = sat_sum(sat_sum(d_sum <<< 25, W_HI <<< 16 | 64'hFFFF), 1);
		else
			err = sat_sum(d_sum <<< 25, -y_sum);
		for (int n = 0; n < TAPS; n++) begin
			prod    = {64'd0, abs64(err)} * {64'd0, abs64(longint'(taps_hist[n]))};
			shifted = prod >> STEP_SHIFT;
			if (shifted > (128'd1 << 48)) shifted = 128'd1 << 48;
			step = longint'(shifted[63:0]);
			if ((err < 0) != (taps_hist[n] < 0)) step = -step;
			w_new = weights[n] + step;
			if (w_new > W_HI) w_new = W_HI;
			if (w_new < W_LO) w_new = W_LO;
			weights[n] = w_new;
		end
		r.adaptive_out  = whole16(y_sum, Y_FRAC);
		r.reference_out = whole16(d_sum, D_FRAC);
		r.error_out     = whole16(err, Y_FRAC);
		return r;
	endfunction

	// receiver: random stalls, one long hold-off, and a stretch with none
	initial begin
		int        wait_n;
		out_word_t exp_w;
		out_word_t got;
		res_ch.ready = 1'b0;
		rcvd_count   = 0;
		@(posedge arst_n);
		forever begin
			if (rcvd_count == 300)
				wait_n = LONG_HOLD;
			else if (rcvd_count >= 420 && rcvd_count < 480)
				wait_n = 0;
			else
				wait_n = $urandom_range(0, 15);
			if (wait_n > 0) begin
				res_ch.ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
			got = res_ch.data;
			rcvd_count++;
			if (pending_words.size() == 0) begin
				$error("result word %0d with nothing expected", rcvd_count);
				fail_count++;
			end else begin
				exp_w = pending_words.pop_front();
				if (got.adaptive_out !== exp_w.adaptive_out) begin
					$error("adaptive_out expected %0d got %0d",
						exp_w.adaptive_out, got.adaptive_out);
					fail_count++;
				end
				if (got.reference_out !== exp_w.reference_out) begin
					$error("reference_out expected %0d got %0d",
						exp_w.reference_out, got.reference_out);
					fail_count++;
				end
				if (got.error_out !== exp_w.error_out) begin
					$error("error_out expected %0d got %0d",
						exp_w.error_out, got.error_out);
					fail_count++;
				end
			end
		end
	end

	// offer one sample word, random gap first, record the expectation on accept
	task automatic push_sample(smp_t x, bit typed, out_word_t want);
		int        gap;
		out_word_t pred;
		gap = (sent_count >= 420 && sent_count < 480) ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			smp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_ch.data  <= '{sample_in: x};
		smp_ch.valid <= 1'b1;
		do @(posedge clk); while (!(smp_ch.valid && smp_ch.ready));
		pred = lms_advance(x);
		pending_words.push_back(typed ? want : pred);
		sent_count++;
	endtask

	// wait for every result, then let the block settle
	task automatic drain_results();
		smp_ch.valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// valid stays high between back to back writes; the caller drops it
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, smp_t val);
		cfg_ch.data  <= '{index: idx, value: val};
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		if (idx < NREG) ref_coef[idx[CI_W-1:0]] = val;
	endtask

	// draw a sample: mostly small words so the filter converges, some full scale
	function automatic smp_t draw_sample(int mode);
		case (mode)
			0: return smp_t'($urandom_range(0, 511)) - 16'sd256;
			1: return smp_t'($urandom);
			2: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : -16'sd32768;
			default: return smp_t'($urandom_range(0, 8191)) - 16'sd4096;
		endcase
	endfunction

	out_word_t none_w;

	initial begin
		int mode;
		none_w       = '0;
		fail_count   = 0;
		sent_count   = 0;
		smp_ch.valid = 1'b0;
		smp_ch.data  = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		for (int n = 0; n < TAPS; n++) begin
			taps_hist[n] = '0;
			weights[n]   = 0;
		end
		for (int n = 0; n < NREG; n++) ref_coef[n] = COEF_RST;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words with the reset coefficients
		foreach (dir_rows[k])
			push_sample(dir_rows[k].smp, dir_rows[k].typed, dir_rows[k].want);
		drain_results();

		// phases: coefficient extremes, zero, unknown index, then random sets
		for (int ph = 0; ph < 8; ph++) begin
			for (int c = 0; c < NREG; c++) begin
				case (ph)
					0: write_reg(c[CFG_IDX_W-1:0], 16'sh7FFF);
					1: write_reg(c[CFG_IDX_W-1:0], -16'sd32768);
					2: write_reg(c[CFG_IDX_W-1:0], 16'sd0);
					default: write_reg(c[CFG_IDX_W-1:0], smp_t'($urandom));
				endcase
			end
			if (ph == 3) begin
				write_reg(IDX_UNUSED, smp_t'($urandom));
				write_reg(CFG_IDX_W'($urandom_range(NREG, 15)), 16'sh7FFF);
			end
			cfg_ch.valid <= 1'b0;
			for (int k = 0; k < 105; k++) begin
				mode = (k % 40 < 25) ? 0 : $urandom_range(1, 3);
				push_sample(draw_sample(mode), 1'b0, none_w);
			end
			// sender pauses until the block has caught up
			drain_results();
		end

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
